[rtl/core/age_fitness_pareto_survival_core_defines.svh]
// ----------------------------------------------------------------------------
// Age-fitness Pareto survival core: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef AGE_FITNESS_PARETO_SURVIVAL_CORE_DEFINES_SVH
`define AGE_FITNESS_PARETO_SURVIVAL_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/afps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_pkg
// Types and codes shared by the age-fitness Pareto survival core.
// ----------------------------------------------------------------------------
package afps_pkg;

  localparam int FIT_W   = 32;
  localparam int AGE_W   = 16;
  localparam int ENTRY_W = FIT_W + AGE_W;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int TRIAL_W = 13;
  localparam logic [TRIAL_W-1:0] TRIAL_MAX = 13'd8191;
  localparam logic [CNT_W-1:0]   NOM_POP_RESET = 7'd64;

  // Commands
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_TOURN    = 2'd1;
  localparam logic [1:0] CMD_FINALIZE = 2'd2;

  // Outcomes
  localparam logic [2:0] OC_LOADED   = 3'd0;
  localparam logic [2:0] OC_DRAW     = 3'd1;
  localparam logic [2:0] OC_REMOVED  = 3'd2;
  localparam logic [2:0] OC_IGNORED  = 3'd3;
  localparam logic [2:0] OC_ERROR    = 3'd4;
  localparam logic [2:0] OC_SURVIVOR = 3'd5;

  typedef struct packed {
    logic [1:0]       command;
    logic [FIT_W-1:0] entry_fitness;
    logic [AGE_W-1:0] entry_age;
    logic [POS_W-1:0] pick_first;
    logic [POS_W-1:0] pick_second;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [POS_W-1:0] removed_position;
    logic [CNT_W-1:0] live_count;
    logic [FIT_W-1:0] survivor_fitness;
    logic [AGE_W-1:0] survivor_age;
    logic             last_item;
  } out_item_t;

endpackage

[rtl/core/afps_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, data holds when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/age_fitness_pareto_survival_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// age_fitness_pareto_survival_core
// Population store with Pareto tournaments on (fitness, age) and finalize.
// ----------------------------------------------------------------------------
// Entries live in one RAM with registered reads. A tournament reads both
// picks and ends on a draw or, for a removal, reads the last entry and
// moves it into the loser's slot. Finalize runs an insertion sort in the
// RAM when it must truncate, each inserted entry going through a key read,
// a key load, one compare-and-shift step per place moved, a final compare
// unless it reaches the front, and the put; it then emits each survivor
// through the single RAM read port. Each result sits in one output
// register; while it is stalled the core holds and takes no new input.
// ----------------------------------------------------------------------------
module age_fitness_pareto_survival_core #(
  parameter int POP_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  afps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output afps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  localparam int AW = $clog2(POP_DEPTH);
  localparam int CW = $clog2(POP_DEPTH + 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_TR_A    = 9'b000000010,
    ST_TR_B    = 9'b000000100,
    ST_TR_MV   = 9'b000001000,
    ST_SKEY_RD = 9'b000010000,
    ST_SKEY    = 9'b000100000,
    ST_SCMP    = 9'b001000000,
    ST_SPUT    = 9'b010000000,
    ST_EM_RD   = 9'b100000000
  } state_t;

  // Emit output needs its own state; kept apart from the one-hot above
  logic em_out_r, em_out_nxt;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] target_r, target_nxt;
  logic [afps_pkg::TRIAL_W-1:0] trial_r, trial_nxt;
  logic started_r, started_nxt;
  logic [6:0] nom_r;
  logic out_valid_r, out_valid_nxt;
  afps_pkg::out_item_t out_data_r, out_data_nxt;

  logic [AW-1:0] p1_r, p1_nxt;
  logic [AW-1:0] p0_r, p0_nxt;
  logic [AW-1:0] loser_r, loser_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] e_r, e_nxt;
  logic [CW-1:0] sort_n_r, sort_n_nxt;
  logic [afps_pkg::ENTRY_W-1:0] a_r, a_nxt;
  logic [afps_pkg::ENTRY_W-1:0] key_r, key_nxt;

  // RAM port signals
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [afps_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Helpers
  logic out_free;
  logic in_xfer;
  logic [13:0] nom_sq;
  logic [afps_pkg::TRIAL_W-1:0] budget;
  logic [CW-1:0] tgt_eff;
  logic [afps_pkg::TRIAL_W-1:0] trial_eff;
  logic [CW-1:0] cnt_dec;
  logic [CW-1:0] fin_cnt;
  logic [afps_pkg::FIT_W-1:0] fa, fb;
  logic [afps_pkg::AGE_W-1:0] aa, ab;
  logic dom_ab, dom_ba;
  logic em_last;

  afps_ram #(
    .WIDTH(afps_pkg::ENTRY_W),
    .DEPTH(POP_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && !em_out_r && out_free);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Trial budget: square of the nominal size, saturated
  assign nom_sq  = nom_r * nom_r;
  assign budget  = (nom_sq > 14'(afps_pkg::TRIAL_MAX)) ? afps_pkg::TRIAL_MAX
                                                       : nom_sq[12:0];
  assign tgt_eff   = started_r ? target_r : (count_r >> 1);
  assign trial_eff = started_r ? trial_r : '0;
  assign cnt_dec   = count_r - CW'(1);
  assign fin_cnt   = (count_r > tgt_eff) ? tgt_eff : count_r;

  // Pareto dominance between the two tournament entries
  assign fa = a_r[afps_pkg::ENTRY_W-1:afps_pkg::AGE_W];
  assign aa = a_r[afps_pkg::AGE_W-1:0];
  assign fb = ram_rdata[afps_pkg::ENTRY_W-1:afps_pkg::AGE_W];
  assign ab = ram_rdata[afps_pkg::AGE_W-1:0];
  assign dom_ab = (fa <= fb) && (aa <= ab) && ((fa != fb) || (aa != ab));
  assign dom_ba = (fb <= fa) && (ab <= aa) && ((fa != fb) || (aa != ab));
  assign em_last = ({1'b0, e_r} + CW'(1)) == count_r;

  // Next-state and datapath
  always_comb begin
    state_nxt     = state_r;
    em_out_nxt    = em_out_r;
    count_nxt     = count_r;
    target_nxt    = target_r;
    trial_nxt     = trial_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    loser_nxt     = loser_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    sort_n_nxt    = sort_n_r;
    a_nxt         = a_r;
    key_nxt       = key_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;

    if (em_out_r) begin
      // Survivor emit
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_data_nxt.outcome          = afps_pkg::OC_SURVIVOR;
        out_data_nxt.live_count       = 7'(count_r);
        out_data_nxt.survivor_fitness = ram_rdata[afps_pkg::ENTRY_W-1:afps_pkg::AGE_W];
        out_data_nxt.survivor_age     = ram_rdata[afps_pkg::AGE_W-1:0];
        out_data_nxt.last_item        = em_last;
        em_out_nxt = 1'b0;
        if (em_last) begin
          state_nxt = ST_IDLE;
        end else begin
          e_nxt     = e_r + AW'(1);
          state_nxt = ST_EM_RD;
        end
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            out_data_nxt = '0;
            out_data_nxt.last_item = 1'b1;
            case (in_data.command)
              afps_pkg::CMD_LOAD: begin
                out_valid_nxt = 1'b1;
                if (started_r || (count_r >= CW'(POP_DEPTH))) begin
                  out_data_nxt.outcome    = afps_pkg::OC_ERROR;
                  out_data_nxt.live_count = 7'(count_r);
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = count_r[AW-1:0];
                  ram_wdata = {in_data.entry_fitness, in_data.entry_age};
                  count_nxt = count_r + CW'(1);
                  out_data_nxt.outcome    = afps_pkg::OC_LOADED;
                  out_data_nxt.live_count = 7'(count_r + CW'(1));
                end
              end
              afps_pkg::CMD_TOURN: begin
                started_nxt = 1'b1;
                target_nxt  = tgt_eff;
                trial_nxt   = trial_eff;
                out_data_nxt.live_count = 7'(count_r);
                if ((count_r <= tgt_eff) || (trial_eff >= budget)) begin
                  out_valid_nxt        = 1'b1;
                  out_data_nxt.outcome = afps_pkg::OC_IGNORED;
                end else if (({1'b0, in_data.pick_first} >= 7'(count_r)) ||
                             ({1'b0, in_data.pick_second} >= 7'(count_r))) begin
                  out_valid_nxt        = 1'b1;
                  out_data_nxt.outcome = afps_pkg::OC_ERROR;
                end else begin
                  p0_nxt    = in_data.pick_first[AW-1:0];
                  p1_nxt    = in_data.pick_second[AW-1:0];
                  ram_re    = 1'b1;
                  ram_raddr = in_data.pick_first[AW-1:0];
                  state_nxt = ST_TR_A;
                end
              end
              afps_pkg::CMD_FINALIZE: begin
                started_nxt = 1'b0;
                trial_nxt   = '0;
                target_nxt  = tgt_eff;
                count_nxt   = fin_cnt;
                if (fin_cnt == '0) begin
                  out_valid_nxt           = 1'b1;
                  out_data_nxt.outcome    = afps_pkg::OC_IGNORED;
                  out_data_nxt.live_count = '0;
                end else if (count_r > tgt_eff) begin
                  sort_n_nxt = count_r;
                  i_nxt      = AW'(1);
                  state_nxt  = ST_SKEY_RD;
                end else begin
                  e_nxt     = '0;
                  state_nxt = ST_EM_RD;
                end
              end
              default: begin
                out_valid_nxt           = 1'b1;
                out_data_nxt.outcome    = afps_pkg::OC_ERROR;
                out_data_nxt.live_count = 7'(count_r);
              end
            endcase
          end
        end
        ST_TR_A: begin
          a_nxt     = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = p1_r;
          state_nxt = ST_TR_B;
        end
        ST_TR_B: begin
          if (!dom_ab && !dom_ba) begin
            if (out_free) begin
              trial_nxt     = trial_r + afps_pkg::TRIAL_W'(1);
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_data_nxt.outcome    = afps_pkg::OC_DRAW;
              out_data_nxt.live_count = 7'(count_r);
              out_data_nxt.last_item  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            trial_nxt = trial_r + afps_pkg::TRIAL_W'(1);
            loser_nxt = dom_ab ? p1_r : p0_r;
            count_nxt = cnt_dec;
            ram_re    = 1'b1;
            ram_raddr = cnt_dec[AW-1:0];
            state_nxt = ST_TR_MV;
          end
        end
        ST_TR_MV: begin
          if (out_free) begin
            ram_we        = 1'b1;
            ram_waddr     = loser_r;
            ram_wdata     = ram_rdata;
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_data_nxt.outcome          = afps_pkg::OC_REMOVED;
            out_data_nxt.removed_position = 6'(loser_r);
            out_data_nxt.live_count       = 7'(count_r);
            out_data_nxt.last_item        = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        // Insertion sort over the store
        ST_SKEY_RD: begin
          ram_re    = 1'b1;
          ram_raddr = i_r;
          state_nxt = ST_SKEY;
        end
        ST_SKEY: begin
          key_nxt   = ram_rdata;
          j_nxt     = i_r;
          ram_re    = 1'b1;
          ram_raddr = i_r - AW'(1);
          state_nxt = ST_SCMP;
        end
        ST_SCMP: begin
          if (ram_rdata > key_r) begin
            ram_we    = 1'b1;
            ram_waddr = j_r;
            ram_wdata = ram_rdata;
            j_nxt     = j_r - AW'(1);
            if (j_r == AW'(1)) begin
              state_nxt = ST_SPUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = j_r - AW'(2);
            end
          end else begin
            state_nxt = ST_SPUT;
          end
        end
        ST_SPUT: begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = key_r;
          if (({1'b0, i_r} + CW'(1)) < sort_n_r) begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_SKEY_RD;
          end else begin
            e_nxt     = '0;
            state_nxt = ST_EM_RD;
          end
        end
        ST_EM_RD: begin
          ram_re     = 1'b1;
          ram_raddr  = e_r;
          em_out_nxt = 1'b1;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      em_out_r    <= 1'b0;
      count_r     <= '0;
      target_r    <= '0;
      trial_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
      nom_r       <= afps_pkg::NOM_POP_RESET;
    end else begin
      state_r     <= state_nxt;
      em_out_r    <= em_out_nxt;
      count_r     <= count_nxt;
      target_r    <= target_nxt;
      trial_r     <= trial_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        nom_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    loser_r    <= loser_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    e_r        <= e_nxt;
    sort_n_r   <= sort_n_nxt;
    a_r        <= a_nxt;
    key_r      <= key_nxt;
  end

endmodule

[rtl/core/afps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afps_checker
// Port-level checks for the age-fitness Pareto survival core.
// ----------------------------------------------------------------------------
`include "age_fitness_pareto_survival_core_defines.svh"

module afps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input afps_pkg::out_item_t out_data
);

  logic out_held;
  logic oc_ok;
  logic cnt_ok;
  logic not_surv;
  logic surv_clear;

  assign out_held   = out_valid && out_stall;
  assign oc_ok      = out_data.outcome <= afps_pkg::OC_SURVIVOR;
  assign cnt_ok     = out_data.live_count <= 7'd64;
  assign not_surv   = out_valid && (out_data.outcome != afps_pkg::OC_SURVIVOR);
  assign surv_clear = (out_data.survivor_fitness == '0) && (out_data.survivor_age == '0);

  // A stalled result holds
  `AFPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_data))

  // Outcome code stays in its defined set
  `AFPS_ASSERT_SAME(a_outcome_range, clk, rst_n, out_valid, oc_ok)

  // Live count never exceeds the store
  `AFPS_ASSERT_SAME(a_count_range, clk, rst_n, out_valid, cnt_ok)

  // Survivor fields are zero on any other outcome
  `AFPS_ASSERT_SAME(a_surv_zero, clk, rst_n, not_surv, surv_clear)

endmodule

bind age_fitness_pareto_survival_core afps_checker u_afps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
